@@ hdl/ortx_pkg.sv @@
// Shared types and constants for the on/off-keyed remote code transmitter.
// Used by the front end, the sequencer, the top level and the checker.
// No dependencies.
package ortx_pkg;

	typedef struct packed {
		logic        mode;
		logic [25:0] group_code;
		logic        group_command;
		logic        activate;
		logic [3:0]  device_code;
		logic [7:0]  repeat_count;
	} in_item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic command_rejected;
		logic transmission_done;
	} out_item_t;

	// Classified command as it travels from the front end to the sequencer.
	typedef struct packed {
		logic        is_load;
		logic [31:0] word;
		logic [7:0]  repeats;
	} cmd_t;

	localparam int unsigned CMD_DEPTH_DEF = 4;
	localparam int unsigned RES_DEPTH_DEF = 2;

	localparam logic [15:0] GAP_TICKS_RESET = 16'd40;
	localparam logic [1:0]  REG_GAP_TICKS   = 2'd0;

	// Slot positions inside the marks and the bit cells.
	localparam logic [3:0] START_MARK_SLOT = 4'd4;
	localparam logic [3:0] START_LAST_SLOT = 4'd11;
	localparam logic [3:0] BIT_LAST_SLOT   = 4'd6;
	localparam logic [3:0] ONE_MARK_SLOT   = 4'd5;
	localparam logic [3:0] ZERO_MARK_SLOT  = 4'd2;
	localparam logic [3:0] STOP_LAST_SLOT  = 4'd4;
	localparam logic [3:0] GAP_SLOT        = 4'd5;
	localparam logic [4:0] LAST_BIT        = 5'd31;

endpackage

@@ hdl/ortx_queue.sv @@
// Small first-in first-out queue of fixed-width words.
// Used for the command queue and the result queue; no package dependency.
module ortx_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

@@ hdl/ortx_front.sv @@
// Front end: classifies an incoming item as a load or a slot tick and packs
// the code word. Depends on ortx_pkg.
module ortx_front (
	input  ortx_pkg::in_item_t item,
	output ortx_pkg::cmd_t     pkt
);
	import ortx_pkg::*;

	always_comb begin
		pkt.is_load = item.mode;
		pkt.word    = {item.group_code, item.group_command, item.activate, item.device_code};
		pkt.repeats = item.repeat_count;
	end
endmodule

@@ hdl/ortx_back.sv @@
// Back end: the frame sequencer that turns each command into one line slot.
// Depends on ortx_pkg; reads the gap length from the register in the top level.
module ortx_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  ortx_pkg::cmd_t      pkt,
	input  logic [15:0]         gap_ticks,
	output ortx_pkg::out_item_t res
);
	import ortx_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_START = 2'd1,
		PH_DATA  = 2'd2,
		PH_TAIL  = 2'd3
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [31:0] word_q, word_n;
	logic [7:0]  rep_q, rep_n, rep_dec;
	logic [4:0]  bit_q, bit_n;
	logic [3:0]  slot_q, slot_n;
	logic [15:0] gap_q, gap_n, gap_dec;
	logic        pin_q, pin_n;
	logic        level, rejected, done, cur_bit;

	assign rep_dec = rep_q - 1'b1;
	assign gap_dec = gap_q - 1'b1;
	// The word goes out MSB first, so bit index i selects word bit 31-i.
	assign cur_bit = word_q[~bit_q];

	always_comb begin
		phase_n  = phase_q;
		word_n   = word_q;
		rep_n    = rep_q;
		bit_n    = bit_q;
		slot_n   = slot_q;
		gap_n    = gap_q;
		pin_n    = pin_q;
		level    = 1'b0;
		rejected = 1'b0;
		done     = 1'b0;
		if (pkt.is_load) begin
			level = pin_q;
			if (phase_q != PH_IDLE) begin
				rejected = 1'b1;
			end else begin
				word_n  = pkt.word;
				rep_n   = pkt.repeats;
				bit_n   = '0;
				slot_n  = '0;
				gap_n   = '0;
				phase_n = (pkt.repeats != '0) ? PH_START : PH_IDLE;
			end
		end else begin
			unique case (phase_q)
				PH_START: begin
					level = (slot_q == START_MARK_SLOT);
					if (slot_q >= START_LAST_SLOT) begin
						slot_n  = '0;
						bit_n   = '0;
						phase_n = PH_DATA;
					end else begin
						slot_n = slot_q + 1'b1;
					end
				end
				PH_DATA: begin
					if (slot_q == '0) begin
						level = 1'b1;
					end else if (cur_bit) begin
						level = (slot_q == ONE_MARK_SLOT);
					end else begin
						level = (slot_q == ZERO_MARK_SLOT);
					end
					if (slot_q >= BIT_LAST_SLOT) begin
						slot_n = '0;
						if (bit_q >= LAST_BIT) begin
							bit_n   = '0;
							phase_n = PH_TAIL;
						end else begin
							bit_n = bit_q + 1'b1;
						end
					end else begin
						slot_n = slot_q + 1'b1;
					end
				end
				PH_TAIL: begin
					// Slots below the gap position form the stop mark.
					if (slot_q < GAP_SLOT) begin
						level = (slot_q == '0);
						if (slot_q == STOP_LAST_SLOT) begin
							if (gap_ticks == '0) begin
								rep_n   = rep_dec;
								bit_n   = '0;
								slot_n  = '0;
								gap_n   = '0;
								done    = (rep_dec == '0);
								phase_n = (rep_dec == '0) ? PH_IDLE : PH_START;
							end else begin
								gap_n  = gap_ticks;
								slot_n = GAP_SLOT;
							end
						end else begin
							slot_n = slot_q + 1'b1;
						end
					end else begin
						gap_n = gap_dec;
						if (gap_dec == '0) begin
							rep_n   = rep_dec;
							bit_n   = '0;
							slot_n  = '0;
							done    = (rep_dec == '0);
							phase_n = (rep_dec == '0) ? PH_IDLE : PH_START;
						end
					end
				end
				default: begin
					level = 1'b0;
				end
			endcase
			pin_n = level;
		end
		res.line_level        = level;
		res.busy_res          = (phase_n != PH_IDLE);
		res.command_rejected  = rejected;
		res.transmission_done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			word_q  <= '0;
			rep_q   <= '0;
			bit_q   <= '0;
			slot_q  <= '0;
			gap_q   <= '0;
			pin_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			word_q  <= word_n;
			rep_q   <= rep_n;
			bit_q   <= bit_n;
			slot_q  <= slot_n;
			gap_q   <= gap_n;
			pin_q   <= pin_n;
		end
	end
endmodule

@@ hdl/ook_remote_code_transmitter.sv @@
// Top level of the on/off-keyed remote code transmitter: front end, command
// queue, frame sequencer, result queue and the gap register. Depends on ortx_pkg.
//
// Every item, load or slot tick, yields exactly one result item, in order.
// The block takes one item per clock cycle while the result queue has room;
// each item is registered in the command queue, its result in the result queue.
// The frame sequencer retires one command from the command queue per cycle
// whenever the result queue has room. The command queue (CMD_DEPTH entries) and
// result queue (RES_DEPTH entries) let each side stall on its own. A load while
// a frame sequence runs is returned with command_rejected set. The gap length
// register sits at byte address 0 and is sampled when each stop mark ends.
module ook_remote_code_transmitter #(
	parameter int unsigned CMD_DEPTH = ortx_pkg::CMD_DEPTH_DEF,
	parameter int unsigned RES_DEPTH = ortx_pkg::RES_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  ortx_pkg::in_item_t  cmd,
	input  logic                pop,
	output logic                empty,
	output ortx_pkg::out_item_t result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import ortx_pkg::*;

	cmd_t        pkt_in, pkt_out;
	out_item_t   res_in;
	logic        cmd_empty, res_full, fire;
	logic [15:0] gap_ticks_q;

	assign pready = 1'b1;
	assign prdata = {16'd0, gap_ticks_q};

	// Only one register exists, so every address decodes to it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_ticks_q <= GAP_TICKS_RESET;
		end else if (psel && penable && pwrite && pready && (paddr >= REG_GAP_TICKS)) begin
			gap_ticks_q <= pwdata[15:0];
		end
	end

	ortx_front u_front (
		.item (cmd),
		.pkt  (pkt_in)
	);

	ortx_queue #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (pkt_in),
		.full    (full),
		.rd_en   (fire),
		.rd_data (pkt_out),
		.empty   (cmd_empty)
	);

	assign fire = !cmd_empty && !res_full;

	ortx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.pkt       (pkt_out),
		.gap_ticks (gap_ticks_q),
		.res       (res_in)
	);

	ortx_queue #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (RES_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fire),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);
endmodule

@@ hdl/ortx_checker.sv @@
// Port-level checks for the transmitter, attached by the bind at the end.
// Depends on ortx_pkg and the top level's port list.
module ortx_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                pop,
	input logic                empty,
	input ortx_pkg::out_item_t result,
	input logic                pready
);
	import ortx_pkg::*;

	// A waiting result stays until it is taken.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed or vanished while waiting");

	// The final slot of a sequence leaves the block idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.transmission_done) |-> !result.busy_res)
		else $error("done reported while still busy");

	// A load is only rejected while a sequence keeps running.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.command_rejected) |-> result.busy_res)
		else $error("load rejected while idle");

	// Rejection comes from loads and completion from ticks, never both.
	a_reject_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(result.command_rejected && result.transmission_done))
		else $error("rejected and done on the same result");

	// The register port never inserts wait states.
	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");
endmodule

bind ook_remote_code_transmitter ortx_checker u_ortx_checker (.*);
